// ----- src/sst_pkg.sv -----
package sst_pkg;

    localparam int POSITION_BITS_DEF = 32;
    localparam int LENGTH_BITS_DEF   = 16;
    localparam int KEYWORD_CHARS_DEF = 8;
    localparam int MAX_TOKENS        = 3;

    typedef enum logic [4:0] {
        M_IDLE, M_IDENT, M_INT, M_NUMDOT, M_FRAC, M_STRING, M_SLASH, M_LINE,
        M_BLOCK, M_BLOCKSTAR, M_BANG, M_EQ, M_LT, M_GT, M_AMP, M_PIPE, M_DONE
    } t_mode;

    localparam logic [5:0] K_EOF    = 6'd0;
    localparam logic [5:0] K_ERR    = 6'd1;
    localparam logic [5:0] K_IDENT  = 6'd2;
    localparam logic [5:0] K_INT    = 6'd3;
    localparam logic [5:0] K_FLOAT  = 6'd4;
    localparam logic [5:0] K_BYTE   = 6'd5;
    localparam logic [5:0] K_STRING = 6'd6;
    localparam logic [5:0] K_DOT    = 6'd16;
    localparam logic [5:0] K_SLASH  = 6'd19;
    localparam logic [5:0] K_NONE   = 6'd0;

    localparam logic [2:0] E_NONE    = 3'd0;
    localparam logic [2:0] E_COMMENT = 3'd1;
    localparam logic [2:0] E_CHAR    = 3'd2;
    localparam logic [2:0] E_DOT     = 3'd3;
    localparam logic [2:0] E_STRING  = 3'd4;

    // One token of a step's output, at full internal widths.
    typedef struct packed {
        logic [5:0]  kind;
        logic [63:0] start;
        logic [31:0] length;
        logic [2:0]  err;
    } t_token;

    // Up to three tokens caused by one byte.
    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
        t_token     tok2;
    } t_burst;

    function automatic logic alpha_char(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic logic numeral_char(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] b);
        case (b)
            "(": return 6'd7;   ")": return 6'd8;   "[": return 6'd9;
            "]": return 6'd10;  "{": return 6'd11;  "}": return 6'd12;
            ":": return 6'd13;  ";": return 6'd14;  ",": return 6'd15;
            ".": return 6'd16;  "-": return 6'd17;  "+": return 6'd18;
            "*": return 6'd20;  "~": return 6'd21;  "^": return 6'd22;
            "%": return 6'd23;
            default: return K_NONE;
        endcase
    endfunction

    function automatic logic [5:0] held_single(input t_mode m);
        case (m)
            M_BANG:  return 6'd25;
            M_EQ:    return 6'd27;
            M_LT:    return 6'd30;
            M_GT:    return 6'd33;
            M_AMP:   return 6'd35;
            default: return 6'd37;
        endcase
    endfunction

    function automatic logic [5:0] held_pair(input t_mode m, input logic [7:0] b);
        case (m)
            M_BANG:  return (b == "=") ? 6'd24 : K_NONE;
            M_EQ:    return (b == "=") ? 6'd26 : K_NONE;
            M_LT:    return (b == "=") ? 6'd28 : ((b == "<") ? 6'd29 : K_NONE);
            M_GT:    return (b == "=") ? 6'd31 : ((b == ">") ? 6'd32 : K_NONE);
            M_AMP:   return (b == "&") ? 6'd34 : K_NONE;
            default: return (b == "|") ? 6'd36 : K_NONE;
        endcase
    endfunction

    // Keyword match on the first eight letters and the word length.
    function automatic logic [5:0] word_kind(input logic [63:0] w, input logic [31:0] len);
        logic [63:0] t;
        t = {w[7:0], w[15:8], w[23:16], w[31:24], w[39:32], w[47:40], w[55:48], w[63:56]};
        case (1'b1)
            len == 5 && t[63:24] == "break":    return 6'd38;
            len == 8 && t == "continue":        return 6'd39;
            len == 4 && t[63:32] == "else":     return 6'd40;
            len == 5 && t[63:24] == "false":    return 6'd41;
            len == 3 && t[63:40] == "for":      return 6'd42;
            len == 8 && t == "function":        return 6'd43;
            len == 2 && t[63:48] == "if":       return 6'd44;
            len == 4 && t[63:32] == "null":     return 6'd45;
            len == 6 && t[63:16] == "return":   return 6'd46;
            len == 4 && t[63:32] == "true":     return 6'd47;
            len == 3 && t[63:40] == "var":      return 6'd48;
            len == 5 && t[63:24] == "while":    return 6'd49;
            default:                            return K_IDENT;
        endcase
    endfunction

endpackage

// ----- src/sst_if.sv -----
interface sst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       end_of_input;
    modport source (output valid, source_byte, end_of_input, input ready);
    modport sink (input valid, source_byte, end_of_input, output ready);
endinterface

interface sst_out_if #(
    parameter int POSITION_BITS = 32,
    parameter int LENGTH_BITS   = 16
);
    logic                     valid;
    logic                     ready;
    logic [5:0]               token_kind;
    logic [POSITION_BITS-1:0] start_position;
    logic [LENGTH_BITS-1:0]   token_length;
    logic [2:0]               error_code;
    logic                     last_of_run;
    modport source (output valid, token_kind, start_position, token_length, error_code,
                    last_of_run, input ready);
    modport sink (input valid, token_kind, start_position, token_length, error_code,
                  last_of_run, output ready);
endinterface

// ----- src/sst_scan.sv -----
module sst_scan
    import sst_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
    parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    output t_burst     o_burst
);
    localparam logic [63:0] POS_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - POSITION_BITS);
    localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF >> (32 - LENGTH_BITS);
    localparam int KW_IDX = $clog2(KEYWORD_CHARS);

    t_mode                    r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_begin, n_begin;
    logic [LENGTH_BITS-1:0]   r_len, n_len;
    logic [7:0]               r_word [KEYWORD_CHARS];
    logic [7:0]               n_word [KEYWORD_CHARS];
    logic [7:0]               r_prev, n_prev;

    logic [63:0] pos64, begin64, pos_inc, word_lo;
    logic [31:0] len32, len_inc;
    logic        in_end, fresh;

    always_comb begin
        pos64   = 64'(r_pos);
        begin64 = 64'(r_begin);
        len32   = 32'(r_len);
        pos_inc = (pos64 < POS_MAX) ? pos64 + 64'd1 : pos64;
        len_inc = (len32 < LEN_MAX) ? len32 + 32'd1 : len32;
        in_end  = i_end || i_byte == 8'd0;
        for (int i = 0; i < 8; i++) begin
            word_lo[i*8 +: 8] = r_word[i];
        end
    end

    // Compute the tokens and next state for one byte.
    always_comb begin
        t_token tk [3];
        logic [1:0] cnt;
        logic [5:0] k;
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_begin = r_begin;
        n_len   = r_len;
        n_prev  = r_prev;
        n_word  = r_word;
        cnt     = 2'd0;
        fresh   = 1'b0;
        for (int i = 0; i < 3; i++) begin
            tk[i] = '0;
        end
        k = held_pair(r_mode, i_byte);
        if (r_mode == M_DONE) begin
            tk[0] = '{K_EOF, pos64, 32'd0, E_NONE};
            cnt = 2'd1;
        end else if (in_end) begin
            case (r_mode)
                M_IDENT: begin
                    tk[0] = '{word_kind(word_lo, len32), begin64, len32, E_NONE}; cnt = 2'd1;
                end
                M_INT: begin tk[0] = '{K_INT, begin64, len32, E_NONE}; cnt = 2'd1; end
                M_FRAC: begin tk[0] = '{K_FLOAT, begin64, len32, E_NONE}; cnt = 2'd1; end
                M_NUMDOT: begin
                    tk[0] = '{K_ERR, pos64 - 64'd1, 32'd0, E_DOT};
                    tk[1] = '{K_DOT, pos64 - 64'd1, 32'd1, E_NONE};
                    cnt = 2'd2;
                end
                M_STRING: begin tk[0] = '{K_ERR, pos64, 32'd0, E_STRING}; cnt = 2'd1; end
                M_SLASH: begin tk[0] = '{K_SLASH, begin64, 32'd1, E_NONE}; cnt = 2'd1; end
                M_BLOCK, M_BLOCKSTAR: begin
                    tk[0] = '{K_ERR, pos64, 32'd0, E_COMMENT}; cnt = 2'd1;
                end
                M_IDLE, M_LINE: cnt = 2'd0;
                default: begin
                    tk[0] = '{held_single(r_mode), begin64, 32'd1, E_NONE}; cnt = 2'd1;
                end
            endcase
            tk[cnt] = '{K_EOF, pos64, 32'd0, E_NONE};
            cnt = cnt + 2'd1;
            n_mode = M_DONE;
        end else begin
            // Extend the current token, or fall through to a fresh scan.
            case (r_mode)
                M_IDLE: fresh = 1'b1;
                M_IDENT: begin
                    if (alpha_char(i_byte) || numeral_char(i_byte)) begin
                        if (len32 < KEYWORD_CHARS) n_word[r_len[KW_IDX-1:0]] = i_byte;
                        n_len = LENGTH_BITS'(len_inc);
                        n_pos = POSITION_BITS'(pos_inc); n_prev = i_byte;
                    end else begin
                        tk[0] = '{word_kind(word_lo, len32), begin64, len32, E_NONE};
                        cnt = 2'd1; fresh = 1'b1;
                    end
                end
                M_INT, M_FRAC: begin
                    if (numeral_char(i_byte) || (i_byte == "." && r_mode == M_INT)) begin
                        n_len = LENGTH_BITS'(len_inc);
                        n_pos = POSITION_BITS'(pos_inc); n_prev = i_byte;
                        if (i_byte == ".") n_mode = M_NUMDOT;
                    end else if (i_byte == "b") begin
                        n_len = LENGTH_BITS'(len_inc);
                        n_pos = POSITION_BITS'(pos_inc); n_prev = i_byte;
                        tk[0] = '{K_BYTE, begin64, len_inc, E_NONE};
                        cnt = 2'd1; n_mode = M_IDLE;
                    end else begin
                        tk[0] = '{(r_mode == M_INT) ? K_INT : K_FLOAT, begin64, len32, E_NONE};
                        cnt = 2'd1; fresh = 1'b1;
                    end
                end
                M_NUMDOT: begin
                    if (numeral_char(i_byte)) begin
                        n_len = LENGTH_BITS'(len_inc);
                        n_pos = POSITION_BITS'(pos_inc); n_prev = i_byte; n_mode = M_FRAC;
                    end else begin
                        tk[0] = '{K_ERR, pos64 - 64'd1, 32'd0, E_DOT};
                        tk[1] = '{K_DOT, pos64 - 64'd1, 32'd1, E_NONE};
                        cnt = 2'd2; fresh = 1'b1;
                    end
                end
                M_STRING: begin
                    if (i_byte == "\"" && r_prev != "\\") begin
                        n_len = LENGTH_BITS'(len_inc);
                        n_pos = POSITION_BITS'(pos_inc); n_prev = i_byte;
                        tk[0] = '{K_STRING, begin64, len_inc, E_NONE};
                        cnt = 2'd1; n_mode = M_IDLE;
                    end else if (i_byte == 8'h0A) begin
                        tk[0] = '{K_ERR, pos64, 32'd0, E_STRING};
                        cnt = 2'd1; fresh = 1'b1;
                    end else begin
                        n_len = LENGTH_BITS'(len_inc);
                        n_pos = POSITION_BITS'(pos_inc); n_prev = i_byte;
                    end
                end
                M_SLASH: begin
                    if (i_byte == "/" || i_byte == "*") begin
                        n_pos = POSITION_BITS'(pos_inc); n_prev = i_byte;
                        n_mode = (i_byte == "/") ? M_LINE : M_BLOCK;
                    end else begin
                        tk[0] = '{K_SLASH, begin64, 32'd1, E_NONE};
                        cnt = 2'd1; fresh = 1'b1;
                    end
                end
                M_LINE: begin
                    n_pos = POSITION_BITS'(pos_inc); n_prev = i_byte;
                    if (i_byte == 8'h0A) n_mode = M_IDLE;
                end
                M_BLOCK, M_BLOCKSTAR: begin
                    n_pos = POSITION_BITS'(pos_inc); n_prev = i_byte;
                    if (r_mode == M_BLOCKSTAR && i_byte == "/") n_mode = M_IDLE;
                    else n_mode = (i_byte == "*") ? M_BLOCKSTAR : M_BLOCK;
                end
                default: begin
                    if (k != K_NONE) begin
                        n_pos = POSITION_BITS'(pos_inc); n_prev = i_byte;
                        tk[0] = '{k, begin64, 32'd2, E_NONE};
                        cnt = 2'd1; n_mode = M_IDLE;
                    end else begin
                        tk[0] = '{held_single(r_mode), begin64, 32'd1, E_NONE};
                        cnt = 2'd1; fresh = 1'b1;
                    end
                end
            endcase
            // Start a new token with this byte.
            if (fresh) begin
                n_pos   = POSITION_BITS'(pos_inc);
                n_prev  = i_byte;
                n_mode  = M_IDLE;
                n_begin = r_pos;
                n_len   = LENGTH_BITS'(1);
                if (alpha_char(i_byte)) begin
                    for (int i = 0; i < KEYWORD_CHARS; i++) n_word[i] = 8'd0;
                    n_word[0] = i_byte;
                    n_mode = M_IDENT;
                end else if (numeral_char(i_byte)) begin
                    n_mode = M_INT;
                end else begin
                    case (i_byte)
                        " ", 8'h09, 8'h0D, 8'h0A: n_mode = M_IDLE;
                        "\"": n_mode = M_STRING;
                        "/": n_mode = M_SLASH;
                        "!": n_mode = M_BANG;
                        "=": n_mode = M_EQ;
                        "<": n_mode = M_LT;
                        ">": n_mode = M_GT;
                        "&": n_mode = M_AMP;
                        "|": n_mode = M_PIPE;
                        default: begin
                            if (single_kind(i_byte) != K_NONE)
                                tk[cnt] = '{single_kind(i_byte), pos64, 32'd1, E_NONE};
                            else
                                tk[cnt] = '{K_ERR, pos_inc, 32'd0, E_CHAR};
                            cnt = cnt + 2'd1;
                        end
                    endcase
                end
            end
        end
        o_burst = '{cnt, tk[0], tk[1], tk[2]};
    end

    // Hold scan state; advance on each accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_pos   <= '0;
            r_begin <= '0;
            r_len   <= '0;
            r_prev  <= '0;
            for (int i = 0; i < KEYWORD_CHARS; i++) r_word[i] <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_begin <= n_begin;
            r_len   <= n_len;
            r_prev  <= n_prev;
            r_word  <= n_word;
        end
    end

`ifndef NO_ASSERTIONS
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == M_DONE |=> r_mode == M_DONE) else $error("left done");
    a_done_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == M_DONE |-> o_burst.count == 2'd1 && o_burst.tok0.kind == K_EOF)
        else $error("done without eof");
    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_end |-> o_burst.count != 2'd0) else $error("end with no token");
    a_pos_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> r_pos >= $past(r_pos)) else $error("position went back");
`endif
endmodule

// ----- src/sst_out_queue.sv -----
module sst_out_queue
    import sst_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int LENGTH_BITS   = LENGTH_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_burst i_burst,
    output logic   o_space,
    sst_out_if.source o_tok
);
    // Two burst slots: one draining, one accepted behind it.
    t_burst     r_slot [2];
    logic [1:0] r_valid, n_valid;
    logic       r_head;
    logic [1:0] r_idx;
    t_token     cur;
    logic       pop, slot_done, tail;

    assign tail    = ~r_head;
    assign o_space = ~r_valid[tail] || (~r_valid[r_head]);

    always_comb begin
        case (r_idx)
            2'd0: cur = r_slot[r_head].tok0;
            2'd1: cur = r_slot[r_head].tok1;
            default: cur = r_slot[r_head].tok2;
        endcase
    end

    assign pop       = o_tok.valid && o_tok.ready;
    assign slot_done = pop && (r_idx + 2'd1 == r_slot[r_head].count);

    assign o_tok.valid          = r_valid[r_head];
    assign o_tok.token_kind     = cur.kind;
    assign o_tok.start_position = POSITION_BITS'(cur.start);
    assign o_tok.token_length   = LENGTH_BITS'(cur.length);
    assign o_tok.error_code     = cur.err;
    assign o_tok.last_of_run    = (r_idx + 2'd1 == r_slot[r_head].count);

    // Drop the drained slot and mark the slot that takes a new burst.
    always_comb begin
        n_valid = r_valid;
        if (slot_done) n_valid[r_head] = 1'b0;
        if (i_push && i_burst.count != 2'd0) begin
            if (!r_valid[r_head] && !slot_done) n_valid[r_head] = 1'b1;
            else n_valid[tail] = 1'b1;
        end
    end

    // Store bursts and walk tokens out of the head slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_head  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            if (slot_done) begin
                r_head <= ~r_head;
                r_idx  <= '0;
            end else if (pop) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (!r_valid[r_head] && !slot_done) r_slot[r_head] <= i_burst;
            else r_slot[tail] <= i_burst;
        end
    end

`ifndef NO_ASSERTIONS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[r_head] |-> r_idx < r_slot[r_head].count) else $error("index past burst");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && i_burst.count != 2'd0 |-> o_space) else $error("queue overrun");
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid[r_head] |-> !r_valid[tail]) else $error("tail without head");
`endif
endmodule

// ----- src/script_source_tokenizer.sv -----
// Streaming tokenizer: one source byte is accepted per cycle when the output
// side keeps up, and each byte yields zero to three tokens (the last of them
// flagged with last_of_run). Tokens leave one per cycle, while the receiver is
// ready, from a two-slot burst queue; the input stalls only while both queue
// slots are in use. A zero byte or end_of_input closes the stream with an eof
// token; every later item yields eof again until reset. Error tokens carry a
// length of zero.
module script_source_tokenizer
    import sst_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
    parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sst_in_if.sink    i_src,
    sst_out_if.source o_tok
);
    t_burst burst;
    logic   space, step;

    assign i_src.ready = space;
    assign step = i_src.valid && i_src.ready;

    sst_scan #(
        .POSITION_BITS(POSITION_BITS),
        .LENGTH_BITS  (LENGTH_BITS),
        .KEYWORD_CHARS(KEYWORD_CHARS)
    ) u_scan (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (step),
        .i_byte (i_src.source_byte),
        .i_end  (i_src.end_of_input),
        .o_burst(burst)
    );

    sst_out_queue #(
        .POSITION_BITS(POSITION_BITS),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (step),
        .i_burst(burst),
        .o_space(space),
        .o_tok  (o_tok)
    );
endmodule
